[rtl/core/tads_pkg.sv]
// Shared types, codes and constants for the three-axis DDA stepper.
package tads_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_SETPOS = 2'd2;
  localparam logic [1:0] REQ_POWER  = 2'd3;

  // Configuration register indexes and widths.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TICKS = 1'b1;

  localparam int DELAY_W = 15;
  localparam int IDLE_W  = 8;
  localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 15'd100;
  localparam logic [IDLE_W-1:0]  IDLE_TICKS_RST = 8'd10;

  // Fold of a move into the first octant.
  typedef struct packed {
    logic swap_xz;
    logic swap_xy;
    logic neg_z;
    logic neg_y;
    logic neg_x;
  } octant_flags_t;

  // Motor update request for one committed item.
  typedef struct packed {
    logic       step_en;
    logic [2:0] move;
    logic [2:0] neg;
    logic       power_set;
    logic       power_on;
  } motor_ctl_t;

  // Phase sequence 0,1,2,3 shown on the port in Gray order 0,1,3,2.
  function automatic logic [1:0] gray2(input logic [1:0] p);
    return {p[1], p[1] ^ p[0]};
  endfunction

endpackage

[rtl/core/tads_fold.sv]
// Start-of-line setup: axis deltas, octant fold and error seed.
module tads_fold
  import tads_pkg::*;
#(
  parameter int W = 16
) (
  input  logic signed [W-1:0] tgt [3],
  input  logic signed [W-1:0] pos [3],
  output octant_flags_t       flags,
  output logic [W:0]          major,
  output logic [W:0]          minor [2],
  output logic signed [W+1:0] err_seed
);

  localparam int DW = W + 1;
  localparam int EW = W + 2;

  logic [DW-1:0] diff [3];
  logic [DW-1:0] mag [3];
  logic [2:0]    neg;
  logic [DW-1:0] b0, b1;
  logic          swap_xy, swap_xz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {tgt[k][W-1], tgt[k]} - {pos[k][W-1], pos[k]};
      neg[k]  = diff[k][DW-1];
      mag[k]  = neg[k] ? (DW'(0) - diff[k]) : diff[k];
    end
    swap_xy  = mag[0] < mag[1];
    b0       = swap_xy ? mag[1] : mag[0];
    b1       = swap_xy ? mag[0] : mag[1];
    swap_xz  = b0 < mag[2];
    major    = swap_xz ? mag[2] : b0;
    minor[0] = b1;
    minor[1] = swap_xz ? b0 : mag[2];
    err_seed = EW'(0) - $signed({2'b00, major[DW-1:1]});
    flags    = '{swap_xz: swap_xz, swap_xy: swap_xy,
                 neg_z: neg[2], neg_y: neg[1], neg_x: neg[0]};
  end

endmodule

[rtl/core/tads_dda.sv]
// One Bresenham point per step period, with unfolding of the pending steps.
module tads_dda
  import tads_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                step_en,
  input  logic                busy,
  input  logic [W:0]          idx,
  input  logic [W:0]          major,
  input  logic [W:0]          minor [2],
  input  logic signed [W+1:0] err [2],
  input  logic [2:0]          pending,
  input  octant_flags_t       flags,
  output logic                busy_next,
  output logic                finish,
  output logic [W:0]          idx_next,
  output logic signed [W+1:0] err_next [2],
  output logic [2:0]          pending_next,
  output logic [2:0]          move,
  output logic [2:0]          neg
);

  localparam int EW = W + 2;

  logic              advance;
  logic signed [EW-1:0] sum [2];
  logic [2:0]        s1, s2;

  always_comb begin
    advance      = step_en && busy && (idx <= major);
    finish       = step_en && busy && !(idx <= major);
    busy_next    = busy && !finish;
    idx_next     = idx;
    pending_next = pending;
    for (int k = 0; k < 2; k++) begin
      sum[k]      = err[k] + $signed({1'b0, minor[k]});
      err_next[k] = err[k];
    end

    // Undo the X/Z swap first, then the X/Y swap.
    s1   = flags.swap_xz ? {pending[0], pending[1], pending[2]} : pending;
    s2   = flags.swap_xy ? {s1[2], s1[0], s1[1]} : s1;
    move = advance ? s2 : 3'b000;
    neg  = {flags.neg_z, flags.neg_y, flags.neg_x};

    if (advance) begin
      idx_next        = idx + 1'b1;
      pending_next[0] = 1'b1;
      for (int k = 0; k < 2; k++) begin
        if (!sum[k][EW-1] && (sum[k] != '0)) begin
          err_next[k]       = sum[k] - $signed({1'b0, major});
          pending_next[k+1] = 1'b1;
        end else begin
          err_next[k]       = sum[k];
          pending_next[k+1] = 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/tads_motor.sv]
// Per-axis phase counters, idle timers and coil power.
module tads_motor
  import tads_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  motor_ctl_t        ctl,
  input  logic [IDLE_W-1:0] idle_ticks,
  output logic [2:0]        coil_next,
  output logic [7:0]        pattern_next
);

  logic [1:0]        phase [3];
  logic [IDLE_W-1:0] idle_cnt [3];
  logic [2:0]        coil;
  logic [1:0]        phase_next [3];
  logic [IDLE_W-1:0] idle_next [3];
  logic [IDLE_W-1:0] cnt_dec;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cnt_dec = '0;
      phase_next[k] = phase[k];
      idle_next[k]  = idle_cnt[k];
      coil_next[k]  = coil[k];
      if (ctl.move[k]) begin
        phase_next[k] = phase[k] + (ctl.neg[k] ? 2'd3 : 2'd1);
        idle_next[k]  = idle_ticks;
        coil_next[k]  = 1'b1;
      end
      // A timer that wraps from zero keeps the coil on.
      if (ctl.step_en) begin
        cnt_dec = idle_next[k] - 1'b1;
        if (cnt_dec == '0) begin
          coil_next[k] = 1'b0;
          idle_next[k] = IDLE_W'(1);
        end else begin
          idle_next[k] = cnt_dec;
        end
      end
      if (ctl.power_set) begin
        coil_next[k] = ctl.power_on;
      end
    end
    pattern_next = {gray2(phase_next[2]), 2'b00, gray2(phase_next[1]),
                    gray2(phase_next[0])};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coil <= '0;
      for (int k = 0; k < 3; k++) begin
        phase[k]    <= '0;
        idle_cnt[k] <= '0;
      end
    end else begin
      coil <= coil_next;
      for (int k = 0; k < 3; k++) begin
        phase[k]    <= phase_next[k];
        idle_cnt[k] <= idle_next[k];
      end
    end
  end

endmodule

[rtl/core/three_axis_dda_stepper_top.sv]
// Top level of the three-axis Bresenham line stepper.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    req_type, target_x/y/z, power_on
//   out      source     out_valid/out_stall  phase_pattern, coil_*_on, line_*, pos_*
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// An item is held in the input register, where the update logic works on it,
// and then moves to the result register, from which its result can transfer.
// One item is accepted per cycle while results are taken.
// Synchronous reset puts the block in the line-done state with coils off.
// A stalled result holds the update stage; the input register then fills and stalls.
module three_axis_dda_stepper_top
  import tads_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_z,
  input  logic                          power_on,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    phase_pattern,
  output logic                          coil_x_on,
  output logic                          coil_y_on,
  output logic                          coil_z_on,
  output logic                          line_idle,
  output logic                          line_finished,
  output logic signed [COORD_WIDTH-1:0] pos_x,
  output logic signed [COORD_WIDTH-1:0] pos_y,
  output logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int EW = W + 2;

  // Configuration.
  logic [DELAY_W-1:0] step_delay;
  logic [IDLE_W-1:0]  idle_ticks;

  // Input register.
  logic                s1_valid;
  logic [1:0]          s1_req;
  logic signed [W-1:0] s1_tgt [3];
  logic                s1_power_on;
  logic                in_accept;
  logic                adv;

  // Line state.
  logic signed [W-1:0]  pos [3];
  logic signed [W-1:0]  tgt [3];
  logic [DW-1:0]        major;
  logic [DW-1:0]        minor [2];
  logic signed [EW-1:0] err [2];
  logic [DW-1:0]        idx;
  octant_flags_t        flags;
  logic                 busy;
  logic [2:0]           pending;
  logic [DELAY_W-1:0]   countdown;

  logic signed [W-1:0]  pos_next [3];
  logic signed [W-1:0]  tgt_next [3];
  logic [DW-1:0]        major_next;
  logic [DW-1:0]        minor_next [2];
  logic signed [EW-1:0] err_next [2];
  logic [DW-1:0]        idx_next;
  octant_flags_t        flags_next;
  logic                 busy_next;
  logic [2:0]           pending_next;
  logic [DELAY_W-1:0]   countdown_next;

  // Fold and DDA results.
  octant_flags_t        f_flags;
  logic [DW-1:0]        f_major;
  logic [DW-1:0]        f_minor [2];
  logic signed [EW-1:0] f_seed;
  logic                 step_en;
  logic                 d_busy, d_finish;
  logic [DW-1:0]        d_idx;
  logic signed [EW-1:0] d_err [2];
  logic [2:0]           d_pending, d_move, d_neg;

  motor_ctl_t  mctl;
  logic [2:0]  coil_next;
  logic [7:0]  pattern_next;

  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign in_accept = in_valid && !in_stall;

  tads_fold #(.W(W)) u_fold (
    .tgt      (s1_tgt),
    .pos      (pos),
    .flags    (f_flags),
    .major    (f_major),
    .minor    (f_minor),
    .err_seed (f_seed)
  );

  tads_dda #(.W(W)) u_dda (
    .step_en      (step_en),
    .busy         (busy),
    .idx          (idx),
    .major        (major),
    .minor        (minor),
    .err          (err),
    .pending      (pending),
    .flags        (flags),
    .busy_next    (d_busy),
    .finish       (d_finish),
    .idx_next     (d_idx),
    .err_next     (d_err),
    .pending_next (d_pending),
    .move         (d_move),
    .neg          (d_neg)
  );

  always_comb begin
    step_en        = 1'b0;
    countdown_next = countdown;
    pos_next       = pos;
    tgt_next       = tgt;
    major_next     = major;
    minor_next     = minor;
    err_next       = err;
    idx_next       = idx;
    flags_next     = flags;
    busy_next      = busy;
    pending_next   = pending;
    mctl           = '0;
    mctl.power_on  = s1_power_on;

    case (s1_req)
      REQ_TICK: begin
        if (countdown <= DELAY_W'(1)) begin
          countdown_next = step_delay;
          step_en        = 1'b1;
        end else begin
          countdown_next = countdown - 1'b1;
        end
        busy_next    = d_busy;
        idx_next     = d_idx;
        err_next     = d_err;
        pending_next = d_pending;
        if (d_finish) begin
          pos_next = tgt;
        end
      end
      REQ_START: begin
        tgt_next     = s1_tgt;
        flags_next   = f_flags;
        major_next   = f_major;
        minor_next   = f_minor;
        err_next[0]  = f_seed;
        err_next[1]  = f_seed;
        idx_next     = '0;
        pending_next = '0;
        busy_next    = 1'b1;
      end
      REQ_SETPOS: begin
        tgt_next = s1_tgt;
        pos_next = s1_tgt;
      end
      REQ_POWER: begin
        mctl.power_set = adv;
      end
      default: begin
        busy_next = busy;
      end
    endcase

    mctl.step_en = step_en && adv;
    mctl.move    = adv ? d_move : 3'b000;
    mctl.neg     = d_neg;
  end

  tads_motor u_motor (
    .clk          (clk),
    .rst          (rst),
    .ctl          (mctl),
    .idle_ticks   (idle_ticks),
    .coil_next    (coil_next),
    .pattern_next (pattern_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req      <= req_type;
      s1_tgt[0]   <= target_x;
      s1_tgt[1]   <= target_y;
      s1_tgt[2]   <= target_z;
      s1_power_on <= power_on;
    end
  end

  // Line state and configuration. The user writes only while the block is idle (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay <= STEP_DELAY_RST;
      idle_ticks <= IDLE_TICKS_RST;
      countdown  <= STEP_DELAY_RST;
      major      <= '0;
      idx        <= '0;
      flags      <= '0;
      busy       <= 1'b0;
      pending    <= '0;
      for (int k = 0; k < 3; k++) begin
        pos[k] <= '0;
        tgt[k] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        minor[k] <= '0;
        err[k]   <= '0;
      end
    end else begin
      if (adv) begin
        countdown <= countdown_next;
        pos       <= pos_next;
        tgt       <= tgt_next;
        major     <= major_next;
        minor     <= minor_next;
        err       <= err_next;
        idx       <= idx_next;
        flags     <= flags_next;
        busy      <= busy_next;
        pending   <= pending_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_DELAY: begin
            step_delay <= cfg_data;
            countdown  <= cfg_data;
          end
          CFG_IDLE_TICKS: begin
            idle_ticks <= cfg_data[IDLE_W-1:0];
          end
          default: begin
            idle_ticks <= idle_ticks;
          end
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phase_pattern <= pattern_next;
      coil_x_on     <= coil_next[0];
      coil_y_on     <= coil_next[1];
      coil_z_on     <= coil_next[2];
      line_idle     <= !busy_next;
      line_finished <= (s1_req == REQ_TICK) && d_finish;
      pos_x         <= pos_next[0];
      pos_y         <= pos_next[1];
      pos_z         <= pos_next[2];
    end
  end

endmodule

[rtl/core/tads_checker.sv]
// Port-level checks on the stepper's result channel, bound to the top level.
module tads_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] phase_pattern,
  input logic       line_idle,
  input logic       line_finished
);

  // A held result keeps its status bits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase_pattern)
      && $stable(line_finished) && $stable(line_idle))
    else $error("held result changed");

  // A line that just finished leaves the block in the line-done state.
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_finished |-> line_idle)
    else $error("finished pulse without line idle");

  // The two unused port bits never carry a phase.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phase_pattern[5:4] == 2'b00)
    else $error("phase pattern bits 5:4 set");

  // Two results in a row can not both report a finished line.
  a_fin_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && line_finished |=> !(out_valid && line_finished))
    else $error("line finished twice in a row");

endmodule

bind three_axis_dda_stepper_top tads_checker u_tads_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .phase_pattern (phase_pattern),
  .line_idle     (line_idle),
  .line_finished (line_finished)
);

[tb/sv/tb_three_axis_dda_stepper_top.sv]
// Self-checking testbench for the three-axis DDA stepper: directed table, then random lines.
module tb_three_axis_dda_stepper_top;
  import tads_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [17:0] span_t;

  typedef struct packed {
    logic [1:0]         req;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               pwr;
  } stim_t;

  typedef struct packed {
    logic [7:0]         pattern;
    logic [2:0]         coil;
    logic               done;
    logic               fin;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } motor_status_t;

  typedef struct packed {
    logic               reconf;
    logic [14:0]        delay;
    logic [7:0]         idle;
    logic [1:0]         req;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               pwr;
    logic [7:0]         reps;
    logic               typed;
    motor_status_t      st;
  } dir_row_t;

  localparam motor_status_t AT_ORIGIN = '{8'h00, 3'b000, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0};
  localparam motor_status_t ALL_ON    = '{8'h00, 3'b111, 1'b1, 1'b0, 16'h0, 16'h0, 16'h0};

  localparam dir_row_t DIR_TAB [14] = '{
    '{1'b0, 15'd0, 8'd0, REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd1, 1'b1, AT_ORIGIN},
    '{1'b0, 15'd0, 8'd0, REQ_POWER,  16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd1, 1'b1, ALL_ON},
    '{1'b0, 15'd0, 8'd0, REQ_POWER,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'd1, 1'b1, AT_ORIGIN},
    '{1'b0, 15'd0, 8'd0, REQ_SETPOS, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, 8'd1, 1'b1,
      '{8'h00, 3'b000, 1'b1, 1'b0, 16'h7FFF, 16'h8000, 16'h0000}},
    '{1'b0, 15'd0, 8'd0, REQ_SETPOS, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 8'd1, 1'b1,
      '{8'h00, 3'b000, 1'b1, 1'b0, 16'h8000, 16'h7FFF, 16'hFFFF}},
    '{1'b0, 15'd0, 8'd0, REQ_SETPOS, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd1, 1'b1, AT_ORIGIN},
    // Fastest stepping, coils released right after each step.
    '{1'b1, 15'd1, 8'd1, REQ_START,  16'h7FFF, 16'h8000, 16'h8000, 1'b0, 8'd1, 1'b0, AT_ORIGIN},
    '{1'b0, 15'd0, 8'd0, REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd2, 1'b0, AT_ORIGIN},
    // A new start drops the long line that is still running.
    '{1'b0, 15'd0, 8'd0, REQ_START,  16'h0003, 16'hFFFE, 16'h0001, 1'b0, 8'd1, 1'b0, AT_ORIGIN},
    '{1'b0, 15'd0, 8'd0, REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd5, 1'b0, AT_ORIGIN},
    // Negative X and Z with both swaps; position is overwritten mid-line.
    '{1'b0, 15'd0, 8'd0, REQ_START,  16'h0000, 16'h0005, 16'hFFF9, 1'b0, 8'd1, 1'b0, AT_ORIGIN},
    '{1'b0, 15'd0, 8'd0, REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd3, 1'b0, AT_ORIGIN},
    '{1'b0, 15'd0, 8'd0, REQ_SETPOS, 16'h000A, 16'h000A, 16'h000A, 1'b0, 8'd1, 1'b0, AT_ORIGIN},
    '{1'b0, 15'd0, 8'd0, REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 1'b0, 8'd7, 1'b0, AT_ORIGIN}
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             req_type;
  logic signed [15:0]     target_x;
  logic signed [15:0]     target_y;
  logic signed [15:0]     target_z;
  logic                   power_on;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             phase_pattern;
  logic                   coil_x_on;
  logic                   coil_y_on;
  logic                   coil_z_on;
  logic                   line_idle;
  logic                   line_finished;
  logic signed [15:0]     pos_x;
  logic signed [15:0]     pos_y;
  logic signed [15:0]     pos_z;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Stepper state as the block should hold it.
  logic [14:0]        cfg_step_delay;
  logic [7:0]         cfg_idle_ticks;
  logic signed [15:0] cur_pos [3];
  logic signed [15:0] cur_tgt [3];
  span_t              line_major;
  span_t              line_minor [2];
  span_t              line_err [2];
  logic [16:0]        line_idx;
  octant_flags_t      fold;
  logic               line_busy;
  logic [2:0]         pend_steps;
  logic [1:0]         ph [3];
  logic [7:0]         idle_cnt [3];
  logic [2:0]         coils;
  logic [15:0]        countdown;
  logic [7:0]         port_bits;

  motor_status_t motor_status_q [$];
  int            errors = 0;
  int            cycle_cnt = 0;
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;

  three_axis_dda_stepper_top #(.COORD_WIDTH(16)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .power_on(power_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .phase_pattern(phase_pattern), .coil_x_on(coil_x_on), .coil_y_on(coil_y_on),
    .coil_z_on(coil_z_on), .line_idle(line_idle), .line_finished(line_finished),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Applies one item to the stepper state and returns the status it reports.
  function automatic motor_status_t advance_stepper(input stim_t it);
    motor_status_t res;
    span_t         d [3];
    span_t         t;
    logic [2:0]    moves;
    logic [2:0]    negs;
    logic [1:0]    p;
    logic          finished;
    int            k;
    finished = 1'b0;
    case (it.req)
      REQ_TICK: begin
        if (countdown <= 16'd1) begin
          countdown = {1'b0, cfg_step_delay};
          if (line_busy) begin
            if ($signed({1'b0, line_idx}) <= line_major) begin
              // Pending steps are in folded axes; undo the swaps before moving.
              moves = pend_steps;
              if (fold.swap_xz) moves = {moves[0], moves[1], moves[2]};
              if (fold.swap_xy) moves = {moves[2], moves[0], moves[1]};
              negs = {fold.neg_z, fold.neg_y, fold.neg_x};
              for (k = 0; k < 3; k++) begin
                if (moves[k]) begin
                  p = negs[k] ? ph[k] - 2'd1 : ph[k] + 2'd1;
                  ph[k] = p;
                  coils[k] = 1'b1;
                  port_bits[(k == 2 ? 6 : 2 * k) +: 2] = {p[1], p[1] ^ p[0]};
                  idle_cnt[k] = cfg_idle_ticks;
                end
              end
              line_idx = line_idx + 17'd1;
              pend_steps = 3'b001;
              for (k = 0; k < 2; k++) begin
                line_err[k] = line_err[k] + line_minor[k];
                if (line_err[k] > 0) begin
                  line_err[k] = line_err[k] - line_major;
                  pend_steps[k + 1] = 1'b1;
                end
              end
            end else begin
              cur_pos = cur_tgt;
              line_busy = 1'b0;
              finished = 1'b1;
            end
          end
          for (k = 0; k < 3; k++) begin
            idle_cnt[k] = idle_cnt[k] - 8'd1;
            if (idle_cnt[k] == 8'd0) begin
              coils[k] = 1'b0;
              idle_cnt[k] = 8'd1;
            end
          end
        end else begin
          countdown = countdown - 16'd1;
        end
      end
      REQ_START, REQ_SETPOS: begin
        cur_tgt[0] = it.x;
        cur_tgt[1] = it.y;
        cur_tgt[2] = it.z;
        if (it.req == REQ_START) begin
          negs = 3'b000;
          for (k = 0; k < 3; k++) begin
            d[k] = cur_tgt[k] - cur_pos[k];
            if (d[k] < 0) begin
              negs[k] = 1'b1;
              d[k] = -d[k];
            end
          end
          fold = '0;
          {fold.neg_z, fold.neg_y, fold.neg_x} = negs;
          if (d[0] < d[1]) begin
            fold.swap_xy = 1'b1;
            t = d[0]; d[0] = d[1]; d[1] = t;
          end
          if (d[0] < d[2]) begin
            fold.swap_xz = 1'b1;
            t = d[0]; d[0] = d[2]; d[2] = t;
          end
          line_major = d[0];
          line_minor[0] = d[1];
          line_minor[1] = d[2];
          line_idx = '0;
          pend_steps = 3'b000;
          line_err[0] = -(d[0] / 2);
          line_err[1] = line_err[0];
          line_busy = 1'b1;
        end else begin
          cur_pos = cur_tgt;
        end
      end
      default: begin
        coils = it.pwr ? 3'b111 : 3'b000;
      end
    endcase
    res.pattern = port_bits;
    res.coil = coils;
    res.done = !line_busy;
    res.fin = finished;
    res.px = cur_pos[0];
    res.py = cur_pos[1];
    res.pz = cur_pos[2];
    return res;
  endfunction

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Offers one item and records its expected status once the transfer happens.
  task automatic offer(input stim_t it, input bit typed, input motor_status_t typed_st);
    motor_status_t pred;
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req_type <= it.req;
    target_x <= it.x;
    target_y <= it.y;
    target_z <= it.z;
    power_on <= it.pwr;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = advance_stepper(it);
    motor_status_q.push_back(typed ? typed_st : pred);
  endtask

  // Waits for every expected status, then writes both registers.
  task automatic reprogram(input logic [14:0] delay, input logic [7:0] idle);
    in_valid <= 1'b0;
    while (motor_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_STEP_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    cfg_index <= CFG_IDLE_TICKS;
    cfg_data <= CFG_DATA_W'(idle);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_step_delay = delay;
    countdown = {1'b0, delay};
    cfg_idle_ticks = idle;
  endtask

  // Mostly short lines followed by ticks, at most 40, sized to finish them at short periods, with some noise.
  task automatic run_lines(input int n_items, input bit with_hold);
    int    sent;
    int    n;
    int    span;
    int    k;
    int    off [3];
    bit    hold_asked;
    stim_t it;
    sent = 0;
    hold_asked = 1'b0;
    while (sent < n_items) begin
      if (with_hold && !hold_asked && sent >= 30) begin
        hold_req = 1'b1;
        hold_asked = 1'b1;
      end
      if ($urandom_range(99) < 12) begin
        it.req = 2'($urandom_range(3));
        it.x = 16'($urandom);
        it.y = 16'($urandom);
        it.z = 16'($urandom);
        it.pwr = 1'($urandom);
        offer(it, 1'b0, AT_ORIGIN);
        sent++;
      end else begin
        span = 0;
        for (k = 0; k < 3; k++) begin
          off[k] = ($urandom_range(7) == 0) ? 0 : $urandom_range(18) - 9;
          if (off[k] > span) span = off[k];
          if (-off[k] > span) span = -off[k];
        end
        it.req = REQ_START;
        it.pwr = 1'($urandom);
        if ($urandom_range(11) == 0) begin
          it.x = 16'($urandom);
          it.y = 16'($urandom);
          it.z = 16'($urandom);
        end else begin
          it.x = 16'(cur_pos[0] + off[0]);
          it.y = 16'(cur_pos[1] + off[1]);
          it.z = 16'(cur_pos[2] + off[2]);
        end
        offer(it, 1'b0, AT_ORIGIN);
        sent++;
        n = (span + 2) * cfg_step_delay + $urandom_range(4);
        if (n > 40) n = 40;
        if (n > n_items - sent) n = n_items - sent;
        repeat (n) begin
          it.req = REQ_TICK;
          if ($urandom_range(99) < 4) begin
            it.req = $urandom_range(1) ? REQ_POWER : REQ_SETPOS;
            it.x = 16'(cur_pos[0] + $urandom_range(6) - 3);
            it.y = 16'(cur_pos[1] + $urandom_range(6) - 3);
            it.z = 16'(cur_pos[2] + $urandom_range(6) - 3);
            it.pwr = 1'($urandom);
          end
          offer(it, 1'b0, AT_ORIGIN);
          sent++;
        end
      end
    end
  endtask

  initial begin : result_sink
    int            hold_left;
    motor_status_t want;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (motor_status_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          errors++;
        end else begin
          want = motor_status_q.pop_front();
          compare_field("phase_pattern", want.pattern, phase_pattern);
          compare_field("coil_x_on", want.coil[0], coil_x_on);
          compare_field("coil_y_on", want.coil[1], coil_y_on);
          compare_field("coil_z_on", want.coil[2], coil_z_on);
          compare_field("line_idle", want.done, line_idle);
          compare_field("line_finished", want.fin, line_finished);
          compare_field("pos_x", want.px, pos_x);
          compare_field("pos_y", want.py, pos_y);
          compare_field("pos_z", want.pz, pos_z);
        end
      end
      // A long hold-off lets the block fill up and stall its input.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 60;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin : stimulus
    stim_t it;
    int    guard;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_TICK;
    target_x <= '0;
    target_y <= '0;
    target_z <= '0;
    power_on <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_STEP_DELAY;
    cfg_data <= '0;
    cfg_step_delay = STEP_DELAY_RST;
    cfg_idle_ticks = IDLE_TICKS_RST;
    for (int k = 0; k < 3; k++) begin
      cur_pos[k] = '0;
      cur_tgt[k] = '0;
      ph[k] = 2'd0;
      idle_cnt[k] = 8'd0;
    end
    line_major = '0;
    line_minor[0] = '0;
    line_minor[1] = '0;
    line_err[0] = '0;
    line_err[1] = '0;
    line_idx = '0;
    fold = '0;
    line_busy = 1'b0;
    pend_steps = 3'b000;
    coils = 3'b000;
    countdown = {1'b0, STEP_DELAY_RST};
    port_bits = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].reconf) reprogram(DIR_TAB[i].delay, DIR_TAB[i].idle);
      it = '{DIR_TAB[i].req, DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].z, DIR_TAB[i].pwr};
      repeat (DIR_TAB[i].reps) offer(it, DIR_TAB[i].typed, DIR_TAB[i].st);
    end

    reprogram(15'd2, 8'd0);
    run_lines(95, 1'b0);
    reprogram(15'd1, 8'd255);
    run_lines(95, 1'b1);
    reprogram(15'd3, 8'd4);
    quiet = 1'b1;
    run_lines(95, 1'b0);
    quiet = 1'b0;
    // Longest period: the countdown only runs down, no step is reached.
    reprogram(15'd32767, 8'd2);
    run_lines(40, 1'b0);
    reprogram(15'd1, 8'd1);
    run_lines(95, 1'b0);

    in_valid <= 1'b0;
    guard = 0;
    while (motor_status_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (motor_status_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, motor_status_q.size());
      errors += motor_status_q.size();
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
